FILE: sv/msc_pkg.sv
package msc_pkg;

    // Field widths
    localparam int GAS_W      = 12;
    localparam int WORD_W     = 32;
    localparam int TIME_W     = 32;
    localparam int WGT_W      = 16;
    localparam int GATE_W     = 18;
    localparam int DEB_W      = 16;
    localparam int LEVEL_W    = 16;
    localparam int VIB_OUT_W  = 18;

    // Fixed-point layout
    localparam int FRAC_W     = 16;
    localparam int AVG_W      = GAS_W + FRAC_W;
    localparam int X_W        = 18;
    localparam int STAGE_W    = X_W + 1;
    localparam int VIB_SHIFT  = 14;

    // Serial multiplier sizing
    localparam int SH_W       = WORD_W - VIB_SHIFT;
    localparam int GDIFF_W    = AVG_W + 1;
    localparam int MC_W       = (SH_W > GDIFF_W) ? SH_W : GDIFF_W;
    localparam int ACC_W      = MC_W + 1;
    localparam int CNT_W      = $clog2(WGT_W);

    // Saturation range of the gated, scaled vibration value
    localparam logic signed [ACC_W-1:0] X_MAX = ACC_W'((1 << (X_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] X_MIN = ~X_MAX;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_CO2_WEIGHT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_GAIN      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WEIGHT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WEIGHT = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = CFG_IDX_W'(5);

    localparam logic [WGT_W-1:0]  RST_CO2_WEIGHT    = WGT_W'(6554);
    localparam logic [WGT_W-1:0]  RST_VIB_GAIN      = WGT_W'(4588);
    localparam logic [GATE_W-1:0] RST_NOISE_GATE    = GATE_W'(50);
    localparam logic [WGT_W-1:0]  RST_FIRST_WEIGHT  = WGT_W'(2621);
    localparam logic [WGT_W-1:0]  RST_SECOND_WEIGHT = WGT_W'(1966);
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_MS   = DEB_W'(300);

    typedef struct packed {
        logic [WGT_W-1:0]  co2_weight;
        logic [WGT_W-1:0]  vib_gain;
        logic [GATE_W-1:0] noise_gate;
        logic [WGT_W-1:0]  first_weight;
        logic [WGT_W-1:0]  second_weight;
        logic [DEB_W-1:0]  debounce_ms;
    } t_cfg;

    // result = trunc0((base * 2^16 + mcand * mplier) / 2^16)
    typedef struct packed {
        logic                    start;
        logic signed [MC_W-1:0]  mcand;
        logic [WGT_W-1:0]        mplier;
        logic signed [ACC_W-1:0] base;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] result;
    } t_mul_rsp;

endpackage

FILE: sv/msc_cfg.sv
module msc_cfg import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.co2_weight    <= RST_CO2_WEIGHT;
            r_cfg.vib_gain      <= RST_VIB_GAIN;
            r_cfg.noise_gate    <= RST_NOISE_GATE;
            r_cfg.first_weight  <= RST_FIRST_WEIGHT;
            r_cfg.second_weight <= RST_SECOND_WEIGHT;
            r_cfg.debounce_ms   <= RST_DEBOUNCE_MS;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            case (i_cfg_index)
                CFG_CO2_WEIGHT:    r_cfg.co2_weight    <= i_cfg_data[WGT_W-1:0];
                CFG_VIB_GAIN:      r_cfg.vib_gain      <= i_cfg_data[WGT_W-1:0];
                CFG_NOISE_GATE:    r_cfg.noise_gate    <= i_cfg_data[GATE_W-1:0];
                CFG_FIRST_WEIGHT:  r_cfg.first_weight  <= i_cfg_data[WGT_W-1:0];
                CFG_SECOND_WEIGHT: r_cfg.second_weight <= i_cfg_data[WGT_W-1:0];
                CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/msc_mul.sv
module msc_mul import msc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_SUM, M_FIX} t_mstate;

    t_mstate                 r_state;
    logic signed [ACC_W-1:0] r_hi;
    logic signed [ACC_W-1:0] r_base;
    logic signed [ACC_W-1:0] r_res;
    logic signed [MC_W-1:0]  r_m;
    logic [WGT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_done;

    logic signed [ACC_W-1:0] n_sum;
    logic signed [ACC_W-1:0] n_fix;
    logic                    w_round;

    // One multiplier bit per cycle: add into the high half, then shift the pair right.
    always_comb begin
        n_sum   = r_hi + (r_lo[0] ? ACC_W'(r_m) : '0);
        // negative with a non-zero remainder: step back towards zero
        w_round = r_hi[ACC_W-1] && (r_lo != '0);
        n_fix   = r_hi + {{(ACC_W-1){1'b0}}, w_round};
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_hi    <= '0;
                        r_lo    <= i_req.mplier;
                        r_m     <= i_req.mcand;
                        r_base  <= i_req.base;
                        r_cnt   <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_hi  <= {n_sum[ACC_W-1], n_sum[ACC_W-1:1]};
                    r_lo  <= {n_sum[0], r_lo[WGT_W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(WGT_W - 1)) begin
                        r_state <= M_SUM;
                    end
                end
                M_SUM: begin
                    r_hi    <= r_hi + r_base;
                    r_state <= M_FIX;
                end
                M_FIX: begin
                    r_res   <= n_fix;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/msc_deb.sv
module msc_deb import msc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now,
    input  logic [DEB_W-1:0]  i_limit,
    output logic              o_presence
);

    logic              r_last;
    logic [TIME_W-1:0] r_change;
    logic              r_flag;
    logic [TIME_W-1:0] w_elapsed;

    assign w_elapsed  = i_now - r_change;
    assign o_presence = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_change <= '0;
            r_flag   <= 1'b0;
        end else if (i_upd) begin
            // an edge restarts the timer, so it can never have expired this tick
            if (i_level != r_last) begin
                r_change <= i_now;
                r_last   <= i_level;
            end else if (w_elapsed > TIME_W'(i_limit)) begin
                r_flag <= !r_last;
            end
        end
    end

endmodule

FILE: sv/multi_sensor_conditioner_unit.sv
// Sensor conditioner: gas exponential average, two-stage vibration smoother with
// gain and noise gate, and time-debounced radar presence.
//
// Input channel i_valid/o_ready carries one sampling tick per word. Output channel
// o_valid/i_ready returns one result word per tick, in order. Registers are written on
// i_cfg_valid/o_cfg_ready (always ready), by the user only while the block idles;
// the block itself does not enforce this.
// Every product runs on one shared shift-and-add multiplier that takes one bit of the
// 16-bit weight per cycle. A tick with vib_valid high needs four products; with
// vib_valid low only the gas product runs. The next word is accepted only once the
// result of the last has gone to the output register.
//
// The result sits in an output register; the next word is accepted while it waits.
// If the receiver still holds off when the following result is ready, the block
// holds that result and accepts nothing more until the register frees.
//
// Synchronous reset restores the register defaults, clears the averages and the
// presence flag, and sets the last radar level high. o_ready is high the cycle after.
module multi_sensor_conditioner_unit import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [GAS_W-1:0]      i_gas_sample,
    input  logic signed [WORD_W-1:0] i_vib_word,
    input  logic                  i_vib_valid,
    input  logic                  i_radar_level,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LEVEL_W-1:0]    o_gas_level,
    output logic [VIB_OUT_W-1:0]  o_vibration_level,
    output logic                  o_presence,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAS_GO,
        S_GAS_WT,
        S_SCL_GO,
        S_SCL_WT,
        S_ST1_GO,
        S_ST1_WT,
        S_ST2_GO,
        S_ST2_WT,
        S_OUT
    } t_state;

    t_state                    r_state;
    t_cfg                      w_cfg;
    t_mul_req                  w_req;
    t_mul_rsp                  w_rsp;

    logic [GAS_W-1:0]          r_gas;
    logic signed [WORD_W-1:0]  r_vib_word;
    logic                      r_vib_valid;
    logic [AVG_W-1:0]          r_avg;
    logic signed [STAGE_W-1:0] r_first;
    logic signed [STAGE_W-1:0] r_second;
    logic signed [X_W-1:0]     r_x;
    logic [VIB_OUT_W-1:0]      r_vib_out;

    logic                      r_out_valid;
    logic [LEVEL_W-1:0]        r_gas_level;
    logic [VIB_OUT_W-1:0]      r_vibration_level;
    logic                      r_presence;

    logic                      w_accept;
    logic                      w_presence;
    logic signed [WORD_W-1:0]  w_sh;
    logic [ACC_W-1:0]          w_mag;
    logic signed [ACC_W-1:0]   w_gated;
    logic signed [X_W-1:0]     n_x;
    logic signed [STAGE_W-1:0] n_second;
    logic [VIB_OUT_W-1:0]      n_vib_out;

    msc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    msc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    msc_deb u_deb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (w_accept),
        .i_level    (i_radar_level),
        .i_now      (i_now_ms),
        .i_limit    (w_cfg.debounce_ms),
        .o_presence (w_presence)
    );

    assign o_ready           = (r_state == S_IDLE);
    assign w_accept          = i_valid && o_ready;
    assign o_valid           = r_out_valid;
    assign o_gas_level       = r_gas_level;
    assign o_vibration_level = r_vibration_level;
    assign o_presence        = r_presence;

    // Gate on the unsaturated magnitude, then clamp to the smoother input range.
    always_comb begin
        w_sh    = r_vib_word >>> VIB_SHIFT;
        w_mag   = w_rsp.result[ACC_W-1] ? -w_rsp.result : w_rsp.result;
        w_gated = (w_mag < ACC_W'(w_cfg.noise_gate)) ? '0 : w_rsp.result;
        if (w_gated > X_MAX) begin
            n_x = X_MAX[X_W-1:0];
        end else if (w_gated < X_MIN) begin
            n_x = X_MIN[X_W-1:0];
        end else begin
            n_x = w_gated[X_W-1:0];
        end
        n_second  = w_rsp.result[STAGE_W-1:0];
        n_vib_out = n_second[STAGE_W-1] ? VIB_OUT_W'(-n_second) : VIB_OUT_W'(n_second);
    end

    // Operands for the shared multiplier, one product per GO state.
    always_comb begin
        w_req.start  = 1'b0;
        w_req.mcand  = '0;
        w_req.mplier = '0;
        w_req.base   = '0;
        case (r_state)
            S_GAS_GO: begin
                w_req.start  = 1'b1;
                w_req.mcand  = MC_W'(signed'({1'b0, r_gas, FRAC_W'(0)}))
                             - MC_W'(signed'({1'b0, r_avg}));
                w_req.mplier = w_cfg.co2_weight;
                w_req.base   = ACC_W'(signed'({1'b0, r_avg}));
            end
            S_SCL_GO: begin
                w_req.start  = 1'b1;
                w_req.mcand  = MC_W'(w_sh);
                w_req.mplier = w_cfg.vib_gain;
            end
            S_ST1_GO: begin
                w_req.start  = 1'b1;
                w_req.mcand  = MC_W'(r_x) - MC_W'(r_first);
                w_req.mplier = w_cfg.first_weight;
                w_req.base   = ACC_W'(r_first);
            end
            S_ST2_GO: begin
                w_req.start  = 1'b1;
                w_req.mcand  = MC_W'(r_first) - MC_W'(r_second);
                w_req.mplier = w_cfg.second_weight;
                w_req.base   = ACC_W'(r_second);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_first     <= '0;
            r_second    <= '0;
        end else begin
            // S_OUT refills the register itself when a word leaves
            if (r_out_valid && i_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_gas       <= i_gas_sample;
                        r_vib_word  <= i_vib_word;
                        r_vib_valid <= i_vib_valid;
                        r_vib_out   <= '0;
                        r_state     <= S_GAS_GO;
                    end
                end
                S_GAS_GO: r_state <= S_GAS_WT;
                S_GAS_WT: begin
                    if (w_rsp.done) begin
                        r_avg   <= w_rsp.result[AVG_W-1:0];
                        // invalid word: leave both smoothers alone
                        r_state <= r_vib_valid ? S_SCL_GO : S_OUT;
                    end
                end
                S_SCL_GO: r_state <= S_SCL_WT;
                S_SCL_WT: begin
                    if (w_rsp.done) begin
                        r_x     <= n_x;
                        r_state <= S_ST1_GO;
                    end
                end
                S_ST1_GO: r_state <= S_ST1_WT;
                S_ST1_WT: begin
                    if (w_rsp.done) begin
                        r_first <= w_rsp.result[STAGE_W-1:0];
                        r_state <= S_ST2_GO;
                    end
                end
                S_ST2_GO: r_state <= S_ST2_WT;
                S_ST2_WT: begin
                    if (w_rsp.done) begin
                        r_second  <= n_second;
                        r_vib_out <= n_vib_out;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_ready) begin
                        r_out_valid       <= 1'b1;
                        r_gas_level       <= r_avg[AVG_W-1 -: LEVEL_W];
                        r_vibration_level <= r_vib_out;
                        r_presence        <= w_presence;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_GAS_WT || r_state == S_SCL_WT ||
                        r_state == S_ST1_WT || r_state == S_ST2_WT))
        else $error("multiplier finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("ready did not drop after a word was accepted");

    a_quiet_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_vib_valid) |-> (r_vib_out == '0))
        else $error("vibration level non-zero for an invalid word");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside the output state");

endmodule

FILE: tb/multi_sensor_conditioner_unit_tb.sv
module multi_sensor_conditioner_unit_tb;
    import msc_pkg::*;

    localparam int     PHASES          = 10;
    localparam int     TICKS_PER_PHASE = 150;
    localparam int     LONG_HOLD       = 400;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     SETTLE_CYCLES   = 200;
    localparam longint Q16_ONE         = 65536;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_DEBOUNCE_MS + 1'b1;

    typedef enum {SET_DEFAULT, SET_MAX, SET_ZERO, SET_RANDOM} t_setting;

    typedef struct {
        logic [GAS_W-1:0]         gas;
        logic signed [WORD_W-1:0] word;
        logic                     vib_ok;
        logic                     level;
        logic [TIME_W-1:0]        now;
    } t_tick;

    typedef struct {
        logic [LEVEL_W-1:0]   gas_level;
        logic [VIB_OUT_W-1:0] vib_level;
        logic                 presence;
    } t_reading;

    typedef struct {
        t_tick    tick;
        logic     typed;
        t_reading want;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [GAS_W-1:0]         i_gas_sample;
    logic signed [WORD_W-1:0] i_vib_word;
    logic                     i_vib_valid;
    logic                     i_radar_level;
    logic [TIME_W-1:0]        i_now_ms;
    logic                     o_valid;
    logic                     i_ready;
    logic [LEVEL_W-1:0]       o_gas_level;
    logic [VIB_OUT_W-1:0]     o_vibration_level;
    logic                     o_presence;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    // conditioner model
    t_cfg                      cfg_model;
    logic [AVG_W-1:0]          gas_avg;
    logic signed [STAGE_W-1:0] stage_one;
    logic signed [STAGE_W-1:0] stage_two;
    logic                      radar_seen;
    logic [TIME_W-1:0]         change_ms;
    logic                      present;

    t_reading expected_readings[$];
    t_row     directed_rows[$];

    // typed-in expectation that travels with the word on the input channel
    logic     typed_due;
    t_reading typed_reading;
    t_reading no_reading;

    logic              steady;
    int                holds_wanted;
    int                holds_done;
    logic [TIME_W-1:0] clock_ms;
    logic              level_now;

    int mismatches;
    int ticks_taken;
    int vib_ticks;
    int readings_checked;
    int cfg_writes;
    int presence_moves;
    int idle_cycles;

    multi_sensor_conditioner_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_gas_sample      (i_gas_sample),
        .i_vib_word        (i_vib_word),
        .i_vib_valid       (i_vib_valid),
        .i_radar_level     (i_radar_level),
        .i_now_ms          (i_now_ms),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_gas_level       (o_gas_level),
        .o_vibration_level (o_vibration_level),
        .o_presence        (o_presence),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void reset_model();
        cfg_model.co2_weight    = RST_CO2_WEIGHT;
        cfg_model.vib_gain      = RST_VIB_GAIN;
        cfg_model.noise_gate    = RST_NOISE_GATE;
        cfg_model.first_weight  = RST_FIRST_WEIGHT;
        cfg_model.second_weight = RST_SECOND_WEIGHT;
        cfg_model.debounce_ms   = RST_DEBOUNCE_MS;
        gas_avg    = '0;
        stage_one  = '0;
        stage_two  = '0;
        radar_seen = 1'b1;
        change_ms  = '0;
        present    = 1'b0;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CO2_WEIGHT:    cfg_model.co2_weight    = data[WGT_W-1:0];
            CFG_VIB_GAIN:      cfg_model.vib_gain      = data[WGT_W-1:0];
            CFG_NOISE_GATE:    cfg_model.noise_gate    = data[GATE_W-1:0];
            CFG_FIRST_WEIGHT:  cfg_model.first_weight  = data[WGT_W-1:0];
            CFG_SECOND_WEIGHT: cfg_model.second_weight = data[WGT_W-1:0];
            CFG_DEBOUNCE_MS:   cfg_model.debounce_ms   = data[DEB_W-1:0];
            default: ;
        endcase
    endfunction

    // truncate the whole new value toward zero, not just the increment
    function automatic longint smooth_q16(input longint stage, input longint x,
                                          input longint w);
        return (stage * Q16_ONE + (x - stage) * w) / Q16_ONE;
    endfunction

    function automatic t_reading condition_tick(input t_tick t);
        t_reading          r;
        longint unsigned   acc;
        longint unsigned   wgt;
        longint            raw;
        longint            sh;
        longint            gain;
        longint            scaled;
        longint            mag;
        longint            s1;
        longint            s2;
        logic [TIME_W-1:0] since;
        logic              was_present;

        wgt     = 64'(cfg_model.co2_weight);
        acc     = longint'(gas_avg) * (Q16_ONE - wgt) + (longint'(t.gas) << FRAC_W) * wgt;
        gas_avg = acc[FRAC_W +: AVG_W];
        r.gas_level = gas_avg[AVG_W-1 -: LEVEL_W];
        r.vib_level = '0;

        if (t.vib_ok) begin
            raw    = longint'(t.word);
            sh     = raw >>> VIB_SHIFT;
            gain   = longint'(cfg_model.vib_gain);
            scaled = sh * gain / Q16_ONE;
            mag    = (scaled < 0) ? -scaled : scaled;
            // gate on the magnitude before saturation; equal to the gate passes
            if (mag < longint'(cfg_model.noise_gate))
                scaled = 0;
            if (scaled > longint'(X_MAX))
                scaled = longint'(X_MAX);
            if (scaled < longint'(X_MIN))
                scaled = longint'(X_MIN);
            s1 = longint'(stage_one);
            s1 = smooth_q16(s1, scaled, longint'(cfg_model.first_weight));
            stage_one = STAGE_W'(s1);
            s2 = longint'(stage_two);
            s2 = smooth_q16(s2, s1, longint'(cfg_model.second_weight));
            stage_two = STAGE_W'(s2);
            r.vib_level = VIB_OUT_W'((s2 < 0) ? -s2 : s2);
        end

        was_present = present;
        if (t.level != radar_seen) begin
            change_ms  = t.now;
            radar_seen = t.level;
        end
        since = t.now - change_ms;
        if (since > TIME_W'(cfg_model.debounce_ms))
            present = ~radar_seen;
        if (present != was_present)
            presence_moves++;
        r.presence = present;
        return r;
    endfunction

    function automatic void add_row(input logic [GAS_W-1:0] gas,
                                    input logic [WORD_W-1:0] word,
                                    input logic vib_ok, input logic level,
                                    input logic [TIME_W-1:0] now, input logic typed,
                                    input logic [LEVEL_W-1:0] gas_level,
                                    input logic [VIB_OUT_W-1:0] vib_level,
                                    input logic presence);
        t_row r;
        r.tick.gas         = gas;
        r.tick.word        = word;
        r.tick.vib_ok      = vib_ok;
        r.tick.level       = level;
        r.tick.now         = now;
        r.typed            = typed;
        r.want.gas_level   = gas_level;
        r.want.vib_level   = vib_level;
        r.want.presence    = presence;
        directed_rows.push_back(r);
    endfunction

    function automatic t_tick next_random_tick();
        t_tick  t;
        longint sh;
        int     pick;

        pick = $urandom_range(0, 19);
        if (pick == 0)
            t.gas = '0;
        else if (pick == 1)
            t.gas = '1;
        else
            t.gas = GAS_W'($urandom);

        case ($urandom_range(0, 9))
            0, 1, 2, 3: t.word = $urandom;
            4, 5, 6: begin
                // near the noise gate: small shifted value, random low bits
                sh     = longint'($urandom_range(0, 4095)) - 2048;
                t.word = WORD_W'((sh <<< VIB_SHIFT)
                                 + longint'($urandom_range(0, 2**VIB_SHIFT - 1)));
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: t.word = 32'h7FFF_FFFF;
                    1: t.word = 32'h8000_0000;
                    2: t.word = '0;
                    default: t.word = '1;
                endcase
            end
            default: begin
                sh     = longint'($urandom_range(0, 65535)) - 32768;
                t.word = WORD_W'((sh <<< VIB_SHIFT)
                                 + longint'($urandom_range(0, 2**VIB_SHIFT - 1)));
            end
        endcase

        t.vib_ok = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 8)
            level_now = ~level_now;
        t.level = level_now;
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 120);
        t.now = clock_ms;
        return t;
    endfunction

    task automatic offer_tick(input t_tick t, input logic typed, input t_reading want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_gas_sample  <= t.gas;
        i_vib_word    <= t.word;
        i_vib_valid   <= t.vib_ok;
        i_radar_level <= t.level;
        i_now_ms      <= t.now;
        typed_due     <= typed;
        typed_reading <= want;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // drop valid and hold until every reading has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_readings.size() != 0);
    endtask

    task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic load_settings(input t_setting mode);
        logic [CFG_DATA_W-1:0] co2, gain, gate, w1, w2, deb;
        case (mode)
            SET_DEFAULT: begin
                co2  = CFG_DATA_W'(RST_CO2_WEIGHT);
                gain = CFG_DATA_W'(RST_VIB_GAIN);
                gate = CFG_DATA_W'(RST_NOISE_GATE);
                w1   = CFG_DATA_W'(RST_FIRST_WEIGHT);
                w2   = CFG_DATA_W'(RST_SECOND_WEIGHT);
                deb  = CFG_DATA_W'(RST_DEBOUNCE_MS);
            end
            SET_MAX: begin
                // bits above a register's width must be dropped
                co2  = '1;
                gain = '1;
                gate = '1;
                w1   = '1;
                w2   = '1;
                deb  = '1;
            end
            SET_ZERO: begin
                co2  = '0;
                gain = '0;
                gate = '0;
                w1   = '0;
                w2   = '0;
                deb  = '0;
            end
            default: begin
                co2  = CFG_DATA_W'($urandom);
                gain = CFG_DATA_W'($urandom);
                gate = ($urandom_range(0, 99) < 80) ? CFG_DATA_W'($urandom_range(0, 400))
                                                    : CFG_DATA_W'($urandom);
                w1   = CFG_DATA_W'($urandom);
                w2   = CFG_DATA_W'($urandom);
                deb  = {2'($urandom), 16'($urandom_range(0, 1000))};
            end
        endcase
        cfg_send(CFG_CO2_WEIGHT, co2);
        cfg_send(CFG_VIB_GAIN, gain);
        cfg_send(CFG_NOISE_GATE, gate);
        cfg_send(CFG_FIRST_WEIGHT, w1);
        cfg_send(CFG_SECOND_WEIGHT, w2);
        cfg_send(CFG_DEBOUNCE_MS, deb);
        cfg_send(CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, 2**CFG_IDX_W - 1)),
                 CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_setting mode;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_gas_sample  <= '0;
        i_vib_word    <= '0;
        i_vib_valid   <= 1'b0;
        i_radar_level <= 1'b1;
        i_now_ms      <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_CO2_WEIGHT;
        i_cfg_data    <= '0;
        typed_due     <= 1'b0;
        no_reading.gas_level = '0;
        no_reading.vib_level = '0;
        no_reading.presence  = 1'b0;
        steady       = 1'b0;
        holds_wanted = 0;
        level_now    = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //      gas       word           ok    lvl   now            typed  gas  vib  pres
        add_row(12'd0,    32'h0000_0000, 1'b1, 1'b1, 32'd0,         1'b1,  '0,  '0,  1'b0);
        // invalid word with a large value, then radar debounce at its edges
        add_row(12'd0,    32'h7FFF_FFFF, 1'b0, 1'b1, 32'd301,       1'b1,  '0,  '0,  1'b0);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b0, 32'd1000,      1'b1,  '0,  '0,  1'b0);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b0, 32'd1300,      1'b1,  '0,  '0,  1'b0);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b0, 32'd1301,      1'b1,  '0,  '0,  1'b1);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FF00, 1'b1,  '0,  '0,  1'b1);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0000_002C, 1'b1,  '0,  '0,  1'b1);
        add_row(12'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0000_002D, 1'b1,  '0,  '0,  1'b0);
        add_row(12'd4095, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0100, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd4095, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0200, 1'b0,  '0,  '0,  1'b0);
        // scaled magnitude exactly on the gate, then one below it, each for both signs
        add_row(12'd4095, 32'h00B2_C000, 1'b1, 1'b1, 32'h0000_0300, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd0,    32'hFF4D_4000, 1'b1, 1'b1, 32'h0000_0310, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd0,    32'h00B2_8000, 1'b1, 1'b1, 32'h0000_0320, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd0,    32'hFF4D_8000, 1'b1, 1'b1, 32'h0000_0330, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd0,    32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0340, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd0,    32'h0000_3FFF, 1'b1, 1'b1, 32'h0000_0350, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd2048, 32'h4000_0000, 1'b0, 1'b1, 32'h0000_0360, 1'b0,  '0,  '0,  1'b0);
        add_row(12'd1,    32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_1000, 1'b0,  '0,  '0,  1'b0);

        foreach (directed_rows[k])
            offer_tick(directed_rows[k].tick, directed_rows[k].typed, directed_rows[k].want);
        wait_for_results();

        clock_ms = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                mode = SET_DEFAULT;
            else if (p == 1)
                mode = SET_MAX;
            else if (p == 2)
                mode = SET_ZERO;
            else
                mode = SET_RANDOM;
            load_settings(mode);
            steady = (p == 4 || p == 7);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                // stall the output while words keep coming, so the block backs up
                if (steady && n == 20)
                    holds_wanted++;
                offer_tick(next_random_tick(), 1'b0, no_reading);
            end
            wait_for_results();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            mismatches++;
        end
        $display("Sent %0d ticks (%0d with a vibration word) over %0d setting phases,",
                 ticks_taken, vib_ticks, PHASES);
        $display("%0d register writes; checked %0d readings, presence moved %0d times.",
                 cfg_writes, readings_checked, presence_moves);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : result_side
        int gap;
        holds_done = 0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (holds_done < holds_wanted) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_reading want;
        t_reading seen;
        t_tick    t;
        logic     moved;
        if (!i_rst_n) begin
            reset_model();
            expected_readings.delete();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            // retire the oldest reading before queueing the word taken at this edge
            if (o_valid && i_ready) begin
                moved = 1'b1;
                readings_checked++;
                seen.gas_level = o_gas_level;
                seen.vib_level = o_vibration_level;
                seen.presence  = o_presence;
                if (expected_readings.size() == 0) begin
                    $error("reading with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (seen.gas_level !== want.gas_level) begin
                        $error("gas_level: expected %0d, got %0d",
                               want.gas_level, seen.gas_level);
                        mismatches++;
                    end
                    if (seen.vib_level !== want.vib_level) begin
                        $error("vibration_level: expected %0d, got %0d",
                               want.vib_level, seen.vib_level);
                        mismatches++;
                    end
                    if (seen.presence !== want.presence) begin
                        $error("presence: expected %0d, got %0d",
                               want.presence, seen.presence);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                moved = 1'b1;
                t.gas    = i_gas_sample;
                t.word   = i_vib_word;
                t.vib_ok = i_vib_valid;
                t.level  = i_radar_level;
                t.now    = i_now_ms;
                seen = condition_tick(t);
                if (typed_due)
                    expected_readings.push_back(typed_reading);
                else
                    expected_readings.push_back(seen);
                ticks_taken++;
                if (t.vib_ok)
                    vib_ticks++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                apply_setting(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if (moved || !(i_valid || i_cfg_valid || expected_readings.size() != 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
